[rtl/mvt_pkg.sv]
package mvt_pkg;

  localparam int WORD_BITS      = 32;
  localparam int FRAC_BITS      = 16;
  localparam int FIELD_BITS     = 32;
  localparam int REG_BITS       = 64;
  localparam int HALF_BITS      = REG_BITS / 2;
  localparam int NUM_REGS       = 8;
  localparam int REG_SEL_BITS   = $clog2(NUM_REGS);
  localparam int CFG_INDEX_BITS = REG_SEL_BITS + 1;
  localparam int DIM            = 4;
  localparam int PROD_BITS      = 2 * WORD_BITS;
  localparam int SUM_BITS       = PROD_BITS + 2;
  localparam int SH_BITS        = SUM_BITS - FRAC_BITS;

  typedef logic [FIELD_BITS-1:0]           field_t;
  typedef logic signed [WORD_BITS-1:0]     word_t;
  typedef logic signed [PROD_BITS-1:0]     prod_t;
  typedef logic signed [SUM_BITS-1:0]      sum_t;
  typedef logic signed [SH_BITS-1:0]       sh_t;
  typedef logic [REG_BITS-1:0]             reg_t;
  typedef logic [CFG_INDEX_BITS-1:0]       cfg_index_t;
  typedef logic [DIM-1:0][WORD_BITS-1:0]   vec_t;
  typedef vec_t [DIM-1:0]                  matrix_t;
  typedef sum_t [DIM-1:0]                  sums_t;

  typedef struct packed {
    logic [DIM-1:0][FIELD_BITS-1:0] vals;
    logic                           sat;
  } result_t;

  localparam reg_t  ONE_LOW  = reg_t'(1) << FRAC_BITS;
  localparam reg_t  ONE_HIGH = ONE_LOW << HALF_BITS;
  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic reg_t reg_reset(input int idx);
    reg_t v;
    v = '0;
    case (idx)
      0: v = ONE_LOW;
      2: v = ONE_HIGH;
      5: v = ONE_LOW;
      7: v = ONE_HIGH;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/mvt_ifs.sv]
interface mvt_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [mvt_pkg::FIELD_BITS-1:0] in_x;
  logic signed [mvt_pkg::FIELD_BITS-1:0] in_y;
  logic signed [mvt_pkg::FIELD_BITS-1:0] in_z;
  logic signed [mvt_pkg::FIELD_BITS-1:0] in_w;

  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface mvt_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [mvt_pkg::FIELD_BITS-1:0] out_x;
  logic signed [mvt_pkg::FIELD_BITS-1:0] out_y;
  logic signed [mvt_pkg::FIELD_BITS-1:0] out_z;
  logic signed [mvt_pkg::FIELD_BITS-1:0] out_w;
  logic                         saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

[rtl/mvt_regs.sv]
module mvt_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  mvt_pkg::cfg_index_t  cfg_index,
  input  mvt_pkg::reg_t        cfg_data,
  output mvt_pkg::matrix_t     matrix
);
  import mvt_pkg::*;

  reg_t regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= reg_reset(i);
      end
    end else if (cfg_we && !cfg_index[CFG_INDEX_BITS-1]) begin
      regs[cfg_index[REG_SEL_BITS-1:0]] <= cfg_data;
    end
  end

  // column-major: column c, rows 0/1 in reg 2c, rows 2/3 in reg 2c+1
  for (genvar j = 0; j < DIM; j++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      assign matrix[j][c] = regs[2*c + j/2][(j%2)*HALF_BITS +: WORD_BITS];
    end
  end

endmodule

[rtl/mvt_lane.sv]
module mvt_lane (
  input  logic           clk,
  input  logic           en,
  input  mvt_pkg::vec_t  row,
  input  mvt_pkg::vec_t  vec,
  output mvt_pkg::sum_t  sum
);
  import mvt_pkg::*;

  prod_t prod [DIM];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < DIM; c++) begin
        prod[c] <= $signed(row[c]) * $signed(vec[c]);
      end
      sum <= sum_t'(prod[0]) + sum_t'(prod[1]) + sum_t'(prod[2]) + sum_t'(prod[3]);
    end
  end

endmodule

[rtl/mvt_merge.sv]
module mvt_merge (
  input  mvt_pkg::sums_t    sums,
  output mvt_pkg::result_t  res
);
  import mvt_pkg::*;

  sh_t             sh   [DIM];
  word_t           clip [DIM];
  logic [DIM-1:0]  hit;

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      sh[j] = sh_t'(sums[j] >>> FRAC_BITS);
      if (sh[j] > sh_t'(WORD_MAX)) begin
        clip[j] = WORD_MAX;
        hit[j]  = 1'b1;
      end else if (sh[j] < sh_t'(WORD_MIN)) begin
        clip[j] = WORD_MIN;
        hit[j]  = 1'b1;
      end else begin
        clip[j] = word_t'(sh[j]);
        hit[j]  = 1'b0;
      end
      res.vals[j] = field_t'(clip[j]);
    end
    res.sat = |hit;
  end

endmodule

[rtl/matrix4_vector_transform_top.sv]
// Pipeline: an accepted input item passes the product register, the sum register
// and the saturating output register; vec_out back-pressure stalls every stage.
// Throughput: one item per cycle unless stalled; four row lanes of four multipliers each.
// Reset: synchronous, active high; clears the pipeline valid flags and loads the identity matrix.
module matrix4_vector_transform_top (
  input  logic                 clk,
  input  logic                 rst,
  mvt_in_if.sink               vec_in,
  mvt_out_if.source            vec_out,
  input  logic                 cfg_we,
  input  mvt_pkg::cfg_index_t  cfg_index,
  input  mvt_pkg::reg_t        cfg_data
);
  import mvt_pkg::*;

  matrix_t  matrix;
  vec_t     vec;
  sums_t    sums;
  result_t  res;
  result_t  out_reg;
  logic     en;
  logic     v1;
  logic     v2;
  logic     ov;

  assign en           = !ov || vec_out.ready;
  assign vec_in.ready = en;

  assign vec[0] = vec_in.in_x[WORD_BITS-1:0];
  assign vec[1] = vec_in.in_y[WORD_BITS-1:0];
  assign vec[2] = vec_in.in_z[WORD_BITS-1:0];
  assign vec[3] = vec_in.in_w[WORD_BITS-1:0];

  mvt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .matrix    (matrix)
  );

  for (genvar j = 0; j < DIM; j++) begin : g_lane
    mvt_lane u_lane (
      .clk (clk),
      .en  (en),
      .row (matrix[j]),
      .vec (vec),
      .sum (sums[j])
    );
  end

  mvt_merge u_merge (
    .sums (sums),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      v1 <= vec_in.valid;
      v2 <= v1;
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_reg <= res;
    end
  end

  assign vec_out.valid     = ov;
  assign vec_out.out_x     = out_reg.vals[0];
  assign vec_out.out_y     = out_reg.vals[1];
  assign vec_out.out_z     = out_reg.vals[2];
  assign vec_out.out_w     = out_reg.vals[3];
  assign vec_out.saturated = out_reg.sat;

endmodule

[verif/mvt_transform_checker.sv]
`timescale 1ns / 1ps

module mvt_transform_checker (
  input  logic                clk,
  input  logic                rst,
  mvt_in_if                   vec_in,
  mvt_out_if                  vec_out,
  input  logic                cfg_we,
  input  mvt_pkg::cfg_index_t cfg_index,
  input  mvt_pkg::reg_t       cfg_data,
  output int                  errors,
  output int                  pending
);
  import mvt_pkg::*;

  localparam int ACC_BITS = SUM_BITS + 2;
  typedef logic signed [ACC_BITS-1:0] acc_t;

  reg_t    matrix_regs [NUM_REGS];
  result_t expected_results [$];
  int      results_seen;

  function automatic word_t matrix_entry(input int row, input int col);
    return word_t'(matrix_regs[2*col + row/2][(row%2)*HALF_BITS +: WORD_BITS]);
  endfunction

  // row j = floor(sum_c M[j][c] * v[c] / 2^FRAC_BITS), clipped to the word range
  function automatic result_t transform_vec(input vec_t v);
    result_t r;
    acc_t    acc;
    acc_t    q;
    r = '0;
    for (int j = 0; j < DIM; j++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++)
        acc = acc + acc_t'(matrix_entry(j, c)) * acc_t'(word_t'(v[c]));
      q = acc >>> FRAC_BITS;
      if (q > acc_t'(WORD_MAX)) begin
        r.vals[j] = WORD_MAX;
        r.sat = 1'b1;
      end else if (q < acc_t'(WORD_MIN)) begin
        r.vals[j] = WORD_MIN;
        r.sat = 1'b1;
      end else begin
        r.vals[j] = q[WORD_BITS-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    vec_t    vin;
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
      for (int d = 0; d < DIM; d++)
        matrix_regs[2*d + d/2][(d%2)*HALF_BITS +: WORD_BITS] = WORD_BITS'(1) << FRAC_BITS;
      expected_results.delete();
    end else begin
      if (vec_in.valid && vec_in.ready) begin
        vin[0] = vec_in.in_x[WORD_BITS-1:0];
        vin[1] = vec_in.in_y[WORD_BITS-1:0];
        vin[2] = vec_in.in_z[WORD_BITS-1:0];
        vin[3] = vec_in.in_w[WORD_BITS-1:0];
        expected_results.push_back(transform_vec(vin));
      end
      if (vec_out.valid && vec_out.ready) begin
        got.vals[0] = vec_out.out_x;
        got.vals[1] = vec_out.out_y;
        got.vals[2] = vec_out.out_z;
        got.vals[3] = vec_out.out_w;
        got.sat     = vec_out.saturated;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d arrived with nothing expected: %h %h %h %h sat %b",
                     results_seen, got.vals[0], got.vals[1], got.vals[2], got.vals[3],
                     got.sat);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                       results_seen, want.vals[0], want.vals[1], want.vals[2],
                       want.vals[3], want.sat, got.vals[0], got.vals[1], got.vals[2],
                       got.vals[3], got.sat);
          end
        end
        results_seen++;
      end
      // indexes past the last register are dropped
      if (cfg_we && !cfg_index[CFG_INDEX_BITS-1])
        matrix_regs[cfg_index[REG_SEL_BITS-1:0]] = cfg_data;
    end
    pending = expected_results.size();
  end

endmodule

[verif/tb_matrix4_vector_transform_top.sv]
`timescale 1ns / 1ps

module tb_matrix4_vector_transform_top;
  import mvt_pkg::*;

  typedef enum int {
    MK_SMALL, MK_FULL, MK_AFFINE, MK_MIXED, MK_IDENTITY, MK_ZERO, MK_ALL_MAX, MK_ALL_MIN
  } mat_kind_e;

  localparam word_t ONE_FX = word_t'(1) <<< FRAC_BITS;
  localparam word_t NEG_ONE_FX = -ONE_FX;
  localparam word_t LSB_NEG = -word_t'(1);

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we;
  cfg_index_t cfg_index;
  reg_t       cfg_data;
  int         mismatches;
  int         outstanding;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  reg_t       next_mat [NUM_REGS];

  mvt_in_if  in_ch ();
  mvt_out_if out_ch ();

  matrix4_vector_transform_top DUT (
    .clk       (clk),
    .rst       (rst),
    .vec_in    (in_ch),
    .vec_out   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mvt_transform_checker chk (
    .clk       (clk),
    .rst       (rst),
    .vec_in    (in_ch),
    .vec_out   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (mismatches),
    .pending   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("tb_matrix4_vector_transform_top NOT OK");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic word_t small_word();
    return word_t'(int'($urandom_range(0, 'h7FFFF)) - 'h40000);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return word_t'($urandom);
      4, 5, 6:    return small_word();
      default: begin
        case ($urandom_range(5))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          3: return ONE_FX;
          4: return NEG_ONE_FX;
          default: return LSB_NEG;
        endcase
      end
    endcase
  endfunction

  task automatic send_vec(input word_t x, input word_t y, input word_t z, input word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x  <= x;
    in_ch.in_y  <= y;
    in_ch.in_z  <= z;
    in_ch.in_w  <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic load_matrix(input mat_kind_e kind);
    word_t v;
    drain_results();
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        case (kind)
          MK_IDENTITY: v = (r == c) ? ONE_FX : '0;
          MK_ALL_MAX:  v = WORD_MAX;
          MK_ALL_MIN:  v = WORD_MIN;
          MK_ZERO:     v = '0;
          MK_SMALL:    v = small_word();
          MK_FULL:     v = word_t'($urandom);
          MK_MIXED:    v = rand_word();
          default: begin
            if (r == DIM - 1)                  v = (c == DIM - 1) ? ONE_FX : '0;
            else if (r == c || c == DIM - 1)   v = small_word();
            else                               v = '0;
          end
        endcase
        next_mat[2*c + r/2][(r%2)*HALF_BITS +: HALF_BITS] = v;
      end
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= next_mat[i];
      @(posedge clk);
    end
    // out-of-range index, must leave the matrix alone
    cfg_index <= cfg_index_t'($urandom_range(NUM_REGS, (1 << CFG_INDEX_BITS) - 1));
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    mat_kind_e kind;
    in_ch.valid <= 1'b0;
    in_ch.in_x  <= '0;
    in_ch.in_y  <= '0;
    in_ch.in_z  <= '0;
    in_ch.in_w  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // identity from reset
    send_vec('0, '0, '0, '0);
    send_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_vec(ONE_FX, NEG_ONE_FX, word_t'(1), LSB_NEG);
    send_vec(LSB_NEG, WORD_MIN, WORD_MAX, '0);

    // saturation both ways, floor on negatives
    load_matrix(MK_ALL_MAX);
    send_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_vec(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    send_vec(LSB_NEG, '0, '0, '0);
    send_vec(ONE_FX, '0, '0, '0);
    send_vec('0, '0, '0, '0);
    load_matrix(MK_ALL_MIN);
    send_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_vec(WORD_MIN, '0, '0, '0);
    send_vec(LSB_NEG, LSB_NEG, '0, '0);
    send_vec(word_t'(1), '0, '0, '0);

    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      kind = mat_kind_e'(p % 8);
      load_matrix(kind);
      repeat (84) send_vec(rand_word(), rand_word(), rand_word(), rand_word());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_matrix4_vector_transform_top OK");
    else
      $display("tb_matrix4_vector_transform_top NOT OK");
    $finish;
  end

endmodule
